// ===== src/ctlb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlb_pkg: shared types and codes of the cursor text line buffer
// Request codes, the edit operation that is sent to every cell of the
// character chain, and the default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlb_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int REQ_W = 3;
  localparam int CHAR_W = 8;

  localparam logic [REQ_W-1:0] REQ_MOVE_LEFT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE_RIGHT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BACKSPACE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PRINT      = 3'd4;

  // Operation applied to every cell of the chain in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CHAR_W-1:0]   ch;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/ctlb_cell.sv =====
// ----------------------------------------------------------------------------
// ctlb_cell: one character position of the text chain
// Holds the character at text position IDX and takes the character of a
// neighbor when text is inserted, deleted or rotated past it.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlb_cell #(
  parameter int CAPACITY = ctlb_pkg::CAPACITY_DEF,
  parameter int IDX      = 0,
  localparam int PW      = $clog2(CAPACITY + 1)
) (
  input  wire                          clk,
  input  wire  ctlb_pkg::cell_ctl_t    ctl,
  input  wire  [PW-1:0]                cursor,
  input  wire  [ctlb_pkg::CHAR_W-1:0]  left_in,
  input  wire  [ctlb_pkg::CHAR_W-1:0]  right_in,
  output logic [ctlb_pkg::CHAR_W-1:0]  data
);

  logic [ctlb_pkg::CHAR_W-1:0] data_r;
  logic [ctlb_pkg::CHAR_W-1:0] data_nxt;

  localparam logic [PW-1:0] POS      = PW'(IDX);
  localparam logic [PW-1:0] POS_NEXT = PW'(IDX + 1);

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      ctlb_pkg::CELL_INSERT: begin
        // The new character lands at the cursor; everything after it moves up.
        if (POS == cursor) begin
          data_nxt = ctl.ch;
        end else if (POS > cursor) begin
          data_nxt = left_in;
        end
      end
      ctlb_pkg::CELL_DELETE: begin
        // Removes the character at cursor - 1; the tail moves down by one.
        if (POS_NEXT >= cursor) begin
          data_nxt = right_in;
        end
      end
      ctlb_pkg::CELL_ROTATE: data_nxt = right_in;
      default:               data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== src/cursor_text_line_buffer_core.sv =====
// ----------------------------------------------------------------------------
// cursor_text_line_buffer_core: line-edit buffer with a cursor
// Text is held in order in a ring of character cells; the cursor and the
// text length are counters. Edits and print requests arrive on the in_
// stream, status and text bytes leave on the out_ stream.
// ----------------------------------------------------------------------------
// Move left, move right, backspace, insert and unknown requests each give
// one status transaction. Print of an empty buffer gives one transaction
// flagged empty. Print of a non-empty buffer gives no transaction when it is
// accepted; then the cell ring makes one full turn, rotating each time the
// output register is free, the first length-many rotations giving the text
// bytes in order with tlast on the final byte. Output stalls stretch the
// turn, and no request is accepted until it completes. The chain content is
// restored by that full turn.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_text_line_buffer_core #(
  parameter int CAPACITY = ctlb_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_in
  input  wire  [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_out, [8] empty_res, [9] dropped, [15:10] zero
  output logic        out_tuser,  // [0] is_text
  output logic        out_tlast
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);
  localparam int CW = ctlb_pkg::CHAR_W;

  localparam logic [PW-1:0] CAP_P  = PW'(CAPACITY);
  localparam logic [KW-1:0] K_LAST = KW'(CAPACITY - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PRINT = 1'b1;

  logic          state_r, state_nxt;
  logic [PW-1:0] cursor_r, cursor_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [KW-1:0] k_r, k_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_text_r, out_text_nxt;
  logic [CW-1:0] out_char_r, out_char_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_drop_r, out_drop_nxt;
  logic          out_last_r, out_last_nxt;

  ctlb_pkg::cell_ctl_t cell_ctl;
  logic [CW-1:0]       cell_data [CAPACITY];

  logic slot_free;
  logic accept;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ctlb_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (gi)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .cursor   (cursor_r),
        .left_in  (cell_data[(gi + CAPACITY - 1) % CAPACITY]),
        .right_in (cell_data[(gi + 1) % CAPACITY]),
        .data     (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_text_nxt  = out_text_r;
    out_char_nxt  = out_char_r;
    out_empty_nxt = out_empty_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    cell_ctl.op   = ctlb_pkg::CELL_HOLD;
    cell_ctl.ch   = in_tdata[CW-1:0];

    if (accept) begin
      out_valid_nxt = 1'b1;
      out_text_nxt  = 1'b0;
      out_char_nxt  = '0;
      out_empty_nxt = 1'b0;
      out_drop_nxt  = 1'b0;
      out_last_nxt  = 1'b1;
      unique case (in_tuser)
        ctlb_pkg::REQ_MOVE_LEFT: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - PW'(1);
          end
        end
        ctlb_pkg::REQ_MOVE_RIGHT: begin
          if (cursor_r != len_r) begin
            cursor_nxt = cursor_r + PW'(1);
          end
        end
        ctlb_pkg::REQ_BACKSPACE: begin
          if (cursor_r != '0) begin
            cell_ctl.op = ctlb_pkg::CELL_DELETE;
            cursor_nxt  = cursor_r - PW'(1);
            len_nxt     = len_r - PW'(1);
          end
        end
        ctlb_pkg::REQ_INSERT: begin
          if (len_r == CAP_P) begin
            out_drop_nxt = 1'b1;
          end else begin
            cell_ctl.op = ctlb_pkg::CELL_INSERT;
            cursor_nxt  = cursor_r + PW'(1);
            len_nxt     = len_r + PW'(1);
          end
        end
        ctlb_pkg::REQ_PRINT: begin
          if (len_r == '0) begin
            out_empty_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_PRINT;
            k_nxt         = '0;
          end
        end
        default: begin
        end
      endcase
    end else if ((state_r == ST_PRINT) && slot_free) begin
      // Cell 0 always holds the next character of the turn.
      cell_ctl.op = ctlb_pkg::CELL_ROTATE;
      if (PW'(k_r) < len_r) begin
        out_valid_nxt = 1'b1;
        out_text_nxt  = 1'b1;
        out_char_nxt  = cell_data[0];
        out_empty_nxt = 1'b0;
        out_drop_nxt  = 1'b0;
        out_last_nxt  = (PW'(k_r) == (len_r - PW'(1)));
      end
      if (k_r == K_LAST) begin
        state_nxt = ST_IDLE;
      end else begin
        k_nxt = k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      len_r       <= len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_text_r  <= out_text_nxt;
    out_char_r  <= out_char_nxt;
    out_empty_r <= out_empty_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_drop_r, out_empty_r, out_char_r};
  assign out_tuser  = out_text_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== dv/cursor_text_line_buffer_core_test.sv =====
// ----------------------------------------------------------------------------
// cursor_text_line_buffer_core_test: self-checking bench for the line buffer
// Drives edit and print requests on the in_ stream and keeps its own copy of
// the text on both sides of the cursor. Every out_ transaction is checked,
// field by field, against the predicted stream. Both sides idle at random,
// with two stretches that run at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_text_line_buffer_core_test;

  localparam int CAPACITY = ctlb_pkg::CAPACITY_DEF;
  localparam int IDLE_PCT = 34;

  typedef struct packed {
    logic                        is_text;
    logic [ctlb_pkg::CHAR_W-1:0] ch;
    logic                        empty;
    logic                        dropped;
    logic                        last;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Predicted text: the bytes left of the cursor with the first at index 0,
  // and the bytes right of it with the one next to the cursor on top.
  logic [ctlb_pkg::CHAR_W-1:0] before_cursor[CAPACITY];
  logic [ctlb_pkg::CHAR_W-1:0] after_cursor[CAPACITY];
  int                          before_len = 0;
  int                          after_len = 0;

  line_result_t      pending_results[$];
  bit                steady = 1'b0;
  int                error_count = 0;
  int                requests_sent = 0;
  int                text_bytes_seen = 0;
  int                refused_inserts = 0;
  int                empty_prints = 0;

  cursor_text_line_buffer_core #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic void push_status(bit dropped);
    line_result_t r;
    r = '{is_text: 1'b0, ch: '0, empty: 1'b0, dropped: dropped, last: 1'b1};
    pending_results.push_back(r);
  endfunction

  // Applies one request to the predicted text and queues what it produces.
  function automatic void edit_line(logic [2:0] req,
                                    logic [ctlb_pkg::CHAR_W-1:0] ch);
    line_result_t r;
    int           n;
    case (req)
      ctlb_pkg::REQ_MOVE_LEFT: begin
        if (before_len > 0) begin
          before_len--;
          after_cursor[after_len] = before_cursor[before_len];
          after_len++;
        end
        push_status(1'b0);
      end
      ctlb_pkg::REQ_MOVE_RIGHT: begin
        if (after_len > 0) begin
          after_len--;
          before_cursor[before_len] = after_cursor[after_len];
          before_len++;
        end
        push_status(1'b0);
      end
      ctlb_pkg::REQ_BACKSPACE: begin
        if (before_len > 0) before_len--;
        push_status(1'b0);
      end
      ctlb_pkg::REQ_INSERT: begin
        if (before_len + after_len >= CAPACITY) begin
          refused_inserts++;
          push_status(1'b1);
        end else begin
          before_cursor[before_len] = ch;
          before_len++;
          push_status(1'b0);
        end
      end
      ctlb_pkg::REQ_PRINT: begin
        n = before_len + after_len;
        if (n == 0) begin
          empty_prints++;
          r = '{is_text: 1'b0, ch: '0, empty: 1'b1, dropped: 1'b0, last: 1'b1};
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < before_len; i++) begin
            r = '{is_text: 1'b1, ch: before_cursor[i], empty: 1'b0, dropped: 1'b0,
                  last: (i == n - 1)};
            pending_results.push_back(r);
          end
          for (int i = after_len - 1; i >= 0; i--) begin
            r = '{is_text: 1'b1, ch: after_cursor[i], empty: 1'b0, dropped: 1'b0,
                  last: (i == 0)};
            pending_results.push_back(r);
          end
        end
      end
      default: push_status(1'b0);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so back-to-back requests need no extra write.
  task automatic send_request(input logic [2:0] req,
                              input logic [ctlb_pkg::CHAR_W-1:0] ch);
    if (take_break()) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while (take_break());
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= ch;
    edit_line(req, ch);
    requests_sent++;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= !take_break();
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: tdata %0h tuser %0b tlast %0b",
               out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.is_text) begin
          $error("is_text: expected %0h, got %0h", want.is_text, out_tuser);
          error_count++;
        end
        if (out_tdata[7:0] !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[8] !== want.empty) begin
          $error("empty_res: expected %0h, got %0h", want.empty, out_tdata[8]);
          error_count++;
        end
        if (out_tdata[9] !== want.dropped) begin
          $error("dropped: expected %0h, got %0h", want.dropped, out_tdata[9]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0h, got %0h", want.last, out_tlast);
          error_count++;
        end
        if (want.is_text) text_bytes_seen++;
      end
    end
  end

  // Boundary cases on a short text, plus the unknown request codes.
  task automatic test_boundaries();
    send_request(ctlb_pkg::REQ_PRINT, 8'h00);
    send_request(ctlb_pkg::REQ_MOVE_LEFT, 8'hFF);
    send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'hFF);
    send_request(ctlb_pkg::REQ_BACKSPACE, 8'h00);
    send_request(3'd5, 8'hFF);
    send_request(3'd6, 8'h55);
    send_request(3'd7, 8'hAA);
    send_request(ctlb_pkg::REQ_INSERT, 8'h00);
    send_request(ctlb_pkg::REQ_INSERT, 8'hFF);
    send_request(ctlb_pkg::REQ_INSERT, 8'hA5);
    send_request(ctlb_pkg::REQ_INSERT, 8'h5A);
    send_request(ctlb_pkg::REQ_PRINT, 8'h00);
    send_request(ctlb_pkg::REQ_MOVE_LEFT, 8'h00);
    send_request(ctlb_pkg::REQ_MOVE_LEFT, 8'h00);
    send_request(ctlb_pkg::REQ_INSERT, 8'h3C);
    send_request(ctlb_pkg::REQ_PRINT, 8'h00);
    send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'h00);
    send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'h00);
    send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'h00);
    send_request(ctlb_pkg::REQ_BACKSPACE, 8'h00);
    for (int i = 0; i < 5; i++) send_request(ctlb_pkg::REQ_MOVE_LEFT, 8'h00);
    send_request(ctlb_pkg::REQ_BACKSPACE, 8'h00);
    send_request(ctlb_pkg::REQ_PRINT, 8'h00);
    stop_sending();
  endtask

  // Fills the buffer from both sides of the cursor, overflows it, prints the
  // full text and then deletes everything.
  task automatic test_fill_and_drain();
    for (int i = 0; i < 40; i++) send_request(ctlb_pkg::REQ_INSERT, 8'($urandom));
    for (int i = 0; i < 15; i++) send_request(ctlb_pkg::REQ_MOVE_LEFT, 8'($urandom));
    while (before_len + after_len < CAPACITY)
      send_request(ctlb_pkg::REQ_INSERT, 8'($urandom));
    for (int i = 0; i < 3; i++) send_request(ctlb_pkg::REQ_INSERT, 8'($urandom));
    send_request(ctlb_pkg::REQ_PRINT, 8'($urandom));
    send_request(ctlb_pkg::REQ_MOVE_LEFT, 8'($urandom));
    send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'($urandom));
    send_request(ctlb_pkg::REQ_PRINT, 8'($urandom));
    while (after_len > 0) send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'($urandom));
    send_request(ctlb_pkg::REQ_MOVE_RIGHT, 8'($urandom));
    // Drain at full rate on both sides.
    steady = 1'b1;
    while (before_len > 0) send_request(ctlb_pkg::REQ_BACKSPACE, 8'($urandom));
    steady = 1'b0;
    send_request(ctlb_pkg::REQ_PRINT, 8'($urandom));
    stop_sending();
  endtask

  // Random mix, weighted toward inserts so the text grows and prints stay
  // interesting; a stretch in the middle runs without idling.
  task automatic test_random_edits();
    int          pick;
    logic [2:0]  req;
    for (int i = 0; i < 110; i++) begin
      steady = (i >= 40 && i < 80);
      pick = $urandom_range(0, 99);
      if (pick < 35)      req = ctlb_pkg::REQ_INSERT;
      else if (pick < 50) req = ctlb_pkg::REQ_MOVE_LEFT;
      else if (pick < 65) req = ctlb_pkg::REQ_MOVE_RIGHT;
      else if (pick < 78) req = ctlb_pkg::REQ_BACKSPACE;
      else if (pick < 92) req = ctlb_pkg::REQ_PRINT;
      else                req = 3'($urandom_range(5, 7));
      send_request(req, 8'($urandom));
    end
    steady = 1'b0;
    stop_sending();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_boundaries();
    test_fill_and_drain();
    test_random_edits();

    while (pending_results.size() != 0) @(posedge clk);
    // A print may still be turning the ring after its last byte.
    repeat (CAPACITY + 16) @(posedge clk);

    $display("Sent %0d requests; checked %0d text bytes, %0d refused inserts,",
             requests_sent, text_bytes_seen, refused_inserts);
    $display("and %0d prints of an empty buffer.", empty_prints);
    if (error_count == 0) begin
      $display("cursor_text_line_buffer_core_test: done, clean");
    end else begin
      $display("cursor_text_line_buffer_core_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d transactions outstanding.", pending_results.size());
    $display("cursor_text_line_buffer_core_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/ctlb_pkg.sv
src/ctlb_cell.sv
src/cursor_text_line_buffer_core.sv
dv/cursor_text_line_buffer_core_test.sv
